// ===== src/weo_pkg.sv =====
// Shared types and constants for the wheel encoder odometry block.
// Used by weo_track, weo_scale and wheel_encoder_odometry_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package weo_pkg;

   localparam int GAIN_BITS      = 24;
   localparam int OUT_BITS       = 48;
   localparam int POS_BITS       = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [GAIN_BITS-1:0] DIST_GAIN_RESET = 24'd2107;
   localparam logic [GAIN_BITS-1:0] TURN_GAIN_RESET = 24'd81047;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIST_GAIN_SIM  = 2'd0,
      CSR_DIST_GAIN_REAL = 2'd1,
      CSR_TURN_GAIN_SIM  = 2'd2,
      CSR_TURN_GAIN_REAL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic primed;
      logic rezero;
      logic mode;
   } track_status_type;

endpackage

`default_nettype wire

// ===== src/weo_track.sv =====
// Wheel tracking state: previous counts, position accumulators, mode and primed flags.
// Unwraps the per-wheel delta and saturates the accumulators; uses weo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module weo_track
   import weo_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int ACC_BITS   = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          enable,
   input  wire        [COUNT_BITS-1:0]  count_left,
   input  wire        [COUNT_BITS-1:0]  count_right,
   input  wire                          mode,
   input  wire                          zero_req,
   output logic signed [ACC_BITS-1:0]   acc_left,
   output logic signed [ACC_BITS-1:0]   acc_right,
   output track_status_type             status
);

   localparam int EW = ((ACC_BITS > COUNT_BITS) ? ACC_BITS : COUNT_BITS) + 1;

   logic        [COUNT_BITS-1:0] prev_left_ff, prev_right_ff;
   logic signed [ACC_BITS-1:0]   acc_left_ff, acc_right_ff;
   logic signed [ACC_BITS-1:0]   acc_left_in, acc_right_in;
   logic                         last_mode_ff, primed_ff;
   logic                         rezero;

   function automatic logic signed [ACC_BITS-1:0] step_acc(
      input logic        [COUNT_BITS-1:0] cur,
      input logic        [COUNT_BITS-1:0] prev,
      input logic signed [ACC_BITS-1:0]   acc
   );
      logic signed [COUNT_BITS-1:0] delta;
      logic signed [EW-1:0]         total;
      logic        [EW-ACC_BITS:0]  top_bits;
      delta    = cur - prev;
      total    = EW'(acc) + EW'(delta);
      top_bits = total[EW-1:ACC_BITS-1];
      if (&top_bits || ~|top_bits) begin
         return total[ACC_BITS-1:0];
      end else if (total[EW-1]) begin
         return {1'b1, {(ACC_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(ACC_BITS-1){1'b1}}};
      end
   endfunction

   assign rezero = !primed_ff || (mode != last_mode_ff) || zero_req;

   always_comb begin
      if (rezero) begin
         acc_left_in  = '0;
         acc_right_in = '0;
      end else begin
         acc_left_in  = step_acc(count_left, prev_left_ff, acc_left_ff);
         acc_right_in = step_acc(count_right, prev_right_ff, acc_right_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         acc_left_ff   <= '0;
         acc_right_ff  <= '0;
         last_mode_ff  <= 1'b0;
         primed_ff     <= 1'b0;
      end else if (enable) begin
         prev_left_ff  <= count_left;
         prev_right_ff <= count_right;
         acc_left_ff   <= acc_left_in;
         acc_right_ff  <= acc_right_in;
         last_mode_ff  <= mode;
         primed_ff     <= 1'b1;
      end
   end

   assign acc_left      = acc_left_ff;
   assign acc_right     = acc_right_ff;
   assign status.primed = primed_ff;
   assign status.rezero = rezero;
   assign status.mode   = last_mode_ff;

endmodule

`default_nettype wire

// ===== src/weo_scale.sv =====
// Gain scaling: floor(value * gain / 2) saturated to the output width.
// Combinational; uses weo_pkg for the gain and output widths.
`timescale 1ns / 1ps
`default_nettype none

module weo_scale
   import weo_pkg::*;
#(
   parameter int IN_BITS = 33
) (
   input  wire signed [IN_BITS-1:0]   value,
   input  wire        [GAIN_BITS-1:0] gain,
   output logic signed [OUT_BITS-1:0] result
);

   localparam int PW = IN_BITS + GAIN_BITS + 1;
   localparam int WW = (PW > OUT_BITS) ? PW : OUT_BITS;

   logic signed [GAIN_BITS:0]   gain_s;
   logic signed [PW-1:0]        prod;
   logic signed [PW-1:0]        half;
   logic signed [WW-1:0]        wide;
   logic        [WW-OUT_BITS:0] top_bits;

   assign gain_s   = {1'b0, gain};
   assign prod     = PW'(value) * PW'(gain_s);
   assign half     = prod >>> 1;
   assign wide     = WW'(half);
   assign top_bits = wide[WW-1:OUT_BITS-1];

   always_comb begin
      if (&top_bits || ~|top_bits) begin
         result = wide[OUT_BITS-1:0];
      end else if (wide[WW-1]) begin
         result = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

// ===== src/wheel_encoder_odometry_top.sv =====
// Top level of the wheel encoder odometry block: beat registers, gain CSRs, pipeline.
// Instantiates weo_track and two weo_scale units; uses weo_pkg.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     left_count, right_count, mode_flag, zero_request
//   rsp      out        rsp_valid/stall     distance, heading, left_position, right_position
//   csr      in         csr_write           csr_index, csr_wdata (24-bit gains)
//
// One beat per cycle sustained while rsp is not stalled; a beat reaches rsp_valid through four
// registers: input, accumulator update, sum and difference, gain multiply and saturate.
// The accumulator update is the feedback loop that sets the rate.
// Synchronous reset clears all valid bits, the tracking state and restores default gains.
// A stall on rsp holds the result; a full stage holds only while the stage after it holds,
// so bubbles close up and req_stall rises once all four stages are full and rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module wheel_encoder_odometry_top
   import weo_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int ACC_BITS   = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire signed [COUNT_BITS-1:0]   req_left_count,
   input  wire signed [COUNT_BITS-1:0]   req_right_count,
   input  wire                           req_mode_flag,
   input  wire                           req_zero_request,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_distance,
   output logic signed [OUT_BITS-1:0]    rsp_heading,
   output logic signed [POS_BITS-1:0]    rsp_left_position,
   output logic signed [POS_BITS-1:0]    rsp_right_position,
   input  wire                           csr_write,
   input  wire        [CSR_INDEX_BITS-1:0] csr_index,
   input  wire        [GAIN_BITS-1:0]    csr_wdata
);

   localparam int PXW = (ACC_BITS > POS_BITS) ? ACC_BITS : POS_BITS;

   logic [GAIN_BITS-1:0] dist_sim_ff, dist_real_ff, turn_sim_ff, turn_real_ff;

   logic                  v0_ff, v1_ff, v2_ff, v3_ff;
   logic                  rdy0, rdy1, rdy2, rdy3;
   logic                  adv01, adv12, adv23;

   logic [COUNT_BITS-1:0] left_ff, right_ff;
   logic                  mode_ff, zreq_ff;

   logic signed [ACC_BITS-1:0] acc_left_w, acc_right_w;
   track_status_type           status;

   logic signed [ACC_BITS:0]   sum_ff, diff_ff;
   logic [GAIN_BITS-1:0]       dgain_ff, tgain_ff;
   logic signed [PXW-1:0]      left_ext, right_ext;
   logic signed [POS_BITS-1:0] lpos2_ff, rpos2_ff;

   logic signed [OUT_BITS-1:0] dist_w, head_w;
   logic signed [OUT_BITS-1:0] dist_ff, head_ff;
   logic signed [POS_BITS-1:0] lpos3_ff, rpos3_ff;

   // Gain registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_sim_ff  <= DIST_GAIN_RESET;
         dist_real_ff <= DIST_GAIN_RESET;
         turn_sim_ff  <= TURN_GAIN_RESET;
         turn_real_ff <= TURN_GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIST_GAIN_SIM:  dist_sim_ff  <= csr_wdata;
            CSR_DIST_GAIN_REAL: dist_real_ff <= csr_wdata;
            CSR_TURN_GAIN_SIM:  turn_sim_ff  <= csr_wdata;
            CSR_TURN_GAIN_REAL: turn_real_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage flow: a stage takes a beat when it is empty or its beat moves on
   assign rdy3  = !v3_ff || !rsp_stall;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign rdy0  = !v0_ff || rdy1;
   assign adv01 = v0_ff && rdy1;
   assign adv12 = v1_ff && rdy2;
   assign adv23 = v2_ff && rdy3;

   assign req_stall = !rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (rdy0 && req_valid) begin
         left_ff  <= req_left_count;
         right_ff <= req_right_count;
         mode_ff  <= req_mode_flag;
         zreq_ff  <= req_zero_request;
      end
   end

   weo_track #(
      .COUNT_BITS (COUNT_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv01),
      .count_left  (left_ff),
      .count_right (right_ff),
      .mode        (mode_ff),
      .zero_req    (zreq_ff),
      .acc_left    (acc_left_w),
      .acc_right   (acc_right_w),
      .status      (status)
   );

   // Sum, difference and gain select
   assign left_ext  = PXW'(acc_left_w);
   assign right_ext = PXW'(acc_right_w);

   always_ff @(posedge clock) begin
      if (adv12) begin
         sum_ff   <= (ACC_BITS+1)'(acc_left_w) + (ACC_BITS+1)'(acc_right_w);
         diff_ff  <= (ACC_BITS+1)'(acc_right_w) - (ACC_BITS+1)'(acc_left_w);
         dgain_ff <= status.mode ? dist_real_ff : dist_sim_ff;
         tgain_ff <= status.mode ? turn_real_ff : turn_sim_ff;
         lpos2_ff <= left_ext[POS_BITS-1:0];
         rpos2_ff <= right_ext[POS_BITS-1:0];
      end
   end

   weo_scale #(.IN_BITS(ACC_BITS+1)) u_scale_dist (
      .value  (sum_ff),
      .gain   (dgain_ff),
      .result (dist_w)
   );

   weo_scale #(.IN_BITS(ACC_BITS+1)) u_scale_head (
      .value  (diff_ff),
      .gain   (tgain_ff),
      .result (head_w)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (adv23) begin
         dist_ff  <= dist_w;
         head_ff  <= head_w;
         lpos3_ff <= lpos2_ff;
         rpos3_ff <= rpos2_ff;
      end
   end

   assign rsp_valid          = v3_ff;
   assign rsp_distance       = dist_ff;
   assign rsp_heading        = head_ff;
   assign rsp_left_position  = lpos3_ff;
   assign rsp_right_position = rpos3_ff;

`ifndef NO_ASSERTIONS
   a_rezero_clears: assert property (@(posedge clock) disable iff (reset)
      (adv01 && status.rezero) |=> (acc_left_w == '0 && acc_right_w == '0))
      else $error("rezero beat left a nonzero position");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(v3_ff) |-> $past(v2_ff))
      else $error("result appeared without a beat in the multiply stage");

   a_reset_unprimed: assert property (@(posedge clock)
      reset |=> !status.primed)
      else $error("tracking state primed right after reset");

   a_tracked_primed: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> status.primed)
      else $error("beat in tracking stage while state is unprimed");
`endif

endmodule

`default_nettype wire

// ===== verif/wheel_encoder_odometry_top_tb.sv =====
// Self-checking bench for wheel_encoder_odometry_top: predicts odometry per accepted beat.
// Needs weo_pkg and the wheel_encoder_odometry_top RTL; nothing else.
`timescale 1ns / 1ps

module wheel_encoder_odometry_top_tb;
   import weo_pkg::*;

   localparam int CNT_W = 16;
   localparam int ACC_W = 32;

   typedef struct packed {
      logic [CNT_W-1:0] left_count;
      logic [CNT_W-1:0] right_count;
      logic             mode_flag;
      logic             zero_request;
   } encoder_beat_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] distance;
      logic signed [OUT_BITS-1:0] heading;
      logic signed [POS_BITS-1:0] left_position;
      logic signed [POS_BITS-1:0] right_position;
   } odometry_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   wire              req_stall;
   encoder_beat_type offered_beat = '0;
   wire              rsp_valid;
   logic             rsp_stall = 1'b0;
   wire signed [OUT_BITS-1:0] rsp_distance;
   wire signed [OUT_BITS-1:0] rsp_heading;
   wire signed [POS_BITS-1:0] rsp_left_position;
   wire signed [POS_BITS-1:0] rsp_right_position;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [GAIN_BITS-1:0]      csr_wdata = '0;

   wheel_encoder_odometry_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_count     (offered_beat.left_count),
      .req_right_count    (offered_beat.right_count),
      .req_mode_flag      (offered_beat.mode_flag),
      .req_zero_request   (offered_beat.zero_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distance       (rsp_distance),
      .rsp_heading        (rsp_heading),
      .rsp_left_position  (rsp_left_position),
      .rsp_right_position (rsp_right_position),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   encoder_beat_type  pending_beats[$];
   odometry_beat_type expected_odometry[$];
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   logic              hold_off = 1'b0;
   int                error_count = 0;

   // odometry state mirror
   logic [CNT_W-1:0]     prev_left_q = '0;
   logic [CNT_W-1:0]     prev_right_q = '0;
   longint               acc_left_q = 0;
   longint               acc_right_q = 0;
   logic                 last_mode_q = 1'b0;
   logic                 primed_q = 1'b0;
   logic [GAIN_BITS-1:0] gain_q [0:3] = '{DIST_GAIN_RESET, DIST_GAIN_RESET,
                                          TURN_GAIN_RESET, TURN_GAIN_RESET};

   logic [CNT_W-1:0] gen_left = '0;
   logic [CNT_W-1:0] gen_right = '0;

   function automatic longint clamp_to(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint wheel_delta(logic [CNT_W-1:0] cur, logic [CNT_W-1:0] prev);
      logic signed [CNT_W-1:0] d;
      d = cur - prev;
      return longint'(d);
   endfunction

   // floor(s * gain / 2), saturated to the output width
   function automatic longint scale_half(longint s, logic [GAIN_BITS-1:0] g);
      longint gl;
      gl = longint'(g);
      return clamp_to((s * gl) >>> 1, OUT_BITS);
   endfunction

   function automatic odometry_beat_type odometry_step(encoder_beat_type b);
      odometry_beat_type    r;
      logic [GAIN_BITS-1:0] dg, tg;
      longint               sum, diff;
      if (!primed_q || b.mode_flag != last_mode_q || b.zero_request) begin
         prev_left_q = b.left_count;
         prev_right_q = b.right_count;
         acc_left_q = 0;
         acc_right_q = 0;
      end
      primed_q = 1'b1;
      last_mode_q = b.mode_flag;
      acc_left_q = clamp_to(acc_left_q + wheel_delta(b.left_count, prev_left_q), ACC_W);
      acc_right_q = clamp_to(acc_right_q + wheel_delta(b.right_count, prev_right_q), ACC_W);
      prev_left_q = b.left_count;
      prev_right_q = b.right_count;
      dg = b.mode_flag ? gain_q[CSR_DIST_GAIN_REAL] : gain_q[CSR_DIST_GAIN_SIM];
      tg = b.mode_flag ? gain_q[CSR_TURN_GAIN_REAL] : gain_q[CSR_TURN_GAIN_SIM];
      sum = acc_left_q + acc_right_q;
      diff = acc_right_q - acc_left_q;
      r.distance = OUT_BITS'(scale_half(sum, dg));
      r.heading = OUT_BITS'(scale_half(diff, tg));
      r.left_position = acc_left_q[POS_BITS-1:0];
      r.right_position = acc_right_q[POS_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : drive
      encoder_beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_odometry.push_back(odometry_step(offered_beat));
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            offered_beat <= next_beat;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      odometry_beat_type want, got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_distance, rsp_heading, rsp_left_position, rsp_right_position};
            if (expected_odometry.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected odometry beat: dist %0d head %0d left %0d right %0d",
                           got.distance, got.heading, got.left_position,
                           got.right_position);
            end else begin
               want = expected_odometry.pop_front();
               if (got.distance !== want.distance || got.heading !== want.heading ||
                   got.left_position !== want.left_position ||
                   got.right_position !== want.right_position) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"odometry mismatch: expected dist %0d head %0d left %0d ",
                               "right %0d, got dist %0d head %0d left %0d right %0d"},
                              want.distance, want.heading, want.left_position,
                              want.right_position, got.distance, got.heading,
                              got.left_position, got.right_position);
               end
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_beat(logic [CNT_W-1:0] l, logic [CNT_W-1:0] r, logic m, logic z);
      encoder_beat_type b;
      b.left_count = l;
      b.right_count = r;
      b.mode_flag = m;
      b.zero_request = z;
      pending_beats.push_back(b);
      gen_left = l;
      gen_right = r;
   endtask

   task automatic push_ramp(int n, logic [CNT_W-1:0] dl, logic [CNT_W-1:0] dr, logic m,
                            logic z_first);
      for (int k = 0; k < n; k++)
         push_beat(gen_left + dl, gen_right + dr, m, z_first && k == 0);
   endtask

   // mostly coherent motion runs, some pure noise
   task automatic push_random(int n);
      int               made, run_len, style;
      logic             m, z_first;
      logic [CNT_W-1:0] dl, dr;
      made = 0;
      m = 1'($urandom_range(1));
      while (made < n) begin
         if ($urandom_range(99) < 15) begin
            push_beat(CNT_W'($urandom), CNT_W'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            made++;
         end else begin
            run_len = $urandom_range(60, 1);
            if ($urandom_range(99) < 30) m = ~m;
            z_first = ($urandom_range(99) < 40);
            style = $urandom_range(2);
            dl = CNT_W'($urandom);
            dr = CNT_W'($urandom);
            for (int k = 0; k < run_len; k++) begin
               if (style == 0) begin
                  dl = CNT_W'($urandom_range(400) - 200);
                  dr = CNT_W'($urandom_range(400) - 200);
               end else if (style == 1) begin
                  dl = CNT_W'($urandom);
                  dr = CNT_W'($urandom);
               end
               push_beat(gen_left + dl, gen_right + dr, m,
                         (z_first && k == 0) || $urandom_range(99) < 2);
            end
            made += run_len;
         end
      end
   endtask

   task automatic write_gain(csr_index_type idx, logic [GAIN_BITS-1:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      gain_q[idx] = v;
   endtask

   task automatic set_gains(logic [GAIN_BITS-1:0] ds, logic [GAIN_BITS-1:0] dr,
                            logic [GAIN_BITS-1:0] ts, logic [GAIN_BITS-1:0] tr);
      write_gain(CSR_DIST_GAIN_SIM, ds);
      write_gain(CSR_DIST_GAIN_REAL, dr);
      write_gain(CSR_TURN_GAIN_SIM, ts);
      write_gain(CSR_TURN_GAIN_REAL, tr);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_odometry.size() != 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed beats at reset gains
      push_beat(16'h0000, 16'h0000, 1'b0, 1'b0);
      push_beat(16'h7FFF, 16'h8000, 1'b0, 1'b0);
      push_beat(16'h8000, 16'h7FFF, 1'b0, 1'b0);
      push_beat(16'hFFFF, 16'h0000, 1'b0, 1'b0);
      push_beat(16'hFFFF, 16'h0000, 1'b0, 1'b1);
      push_beat(16'd100, 16'hFF9C, 1'b0, 1'b0);
      push_beat(16'd100, 16'hFF9C, 1'b1, 1'b0);
      push_beat(16'd200, 16'hFED4, 1'b1, 1'b0);
      push_beat(16'h0000, 16'h0000, 1'b1, 1'b1);
      push_beat(16'h8000, 16'h8000, 1'b1, 1'b0);
      push_beat(16'h8001, 16'h8000, 1'b1, 1'b0);
      push_beat(16'd5, 16'd2, 1'b0, 1'b0);
      push_beat(16'd6, 16'd2, 1'b0, 1'b0);
      push_beat(16'd6, 16'd2, 1'b0, 1'b1);
      push_beat(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
      push_beat(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      push_beat(16'h7FFF, 16'h8000, 1'b1, 1'b1);
      push_beat(16'h0000, 16'hFFFF, 1'b1, 1'b0);
      wait_drained();

      // full-scale gains, drive distance and heading into saturation
      set_gains(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      push_ramp(300, 16'h8000, 16'h8000, 1'b0, 1'b1);
      push_ramp(300, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
      push_ramp(300, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
      push_ramp(8, 16'hFF00, 16'h0100, 1'b0, 1'b0);
      wait_drained();

      set_gains(24'h000000, 24'hFFFFFF, GAIN_BITS'($urandom_range(24'hFFFFFF)), 24'h000000);
      send_idle_pct <= 49;
      push_random(120);
      wait_drained();

      set_gains(GAIN_BITS'($urandom_range(24'hFFFFFF)), GAIN_BITS'($urandom_range(4095)),
                GAIN_BITS'($urandom_range(24'hFFFFFF)), GAIN_BITS'($urandom_range(24'hFFFFFF)));
      send_idle_pct <= 0;
      stall_pct <= 49;
      push_random(120);
      repeat (20) @(posedge clock);
      hold_off <= 1'b1;
      repeat (80) @(posedge clock);
      hold_off <= 1'b0;
      wait_drained();

      set_gains(24'h000001, GAIN_BITS'($urandom_range(24'hFFFFFF)), 24'hFFFFFF,
                GAIN_BITS'($urandom_range(255)));
      send_idle_pct <= 9;
      stall_pct <= 9;
      push_random(120);
      wait_drained();

      set_gains(GAIN_BITS'($urandom_range(24'hFFFFFF)), 24'h000000,
                GAIN_BITS'($urandom_range(65535)), GAIN_BITS'($urandom_range(24'hFFFFFF)));
      send_idle_pct <= 0;
      stall_pct <= 0;
      push_random(120);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("wheel_encoder_odometry_top verification clean");
      end else begin
         $display("wheel_encoder_odometry_top verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("wheel_encoder_odometry_top verification failed");
      $finish;
   end

endmodule
